/* sv/ioenvm_pkg.sv */
// ----------------------------------------------------------------------------
// ioenvm_pkg
// Shared types, offsets, codes and lookup functions for the board I/O
// register block.
// ----------------------------------------------------------------------------
package ioenvm_pkg;

  // Item modes
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_CON_RX = 3'd2;
  localparam logic [2:0] MODE_AUX_RX = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  // Register byte offsets
  localparam logic [11:0] OFF_IO_CTRL  = 12'h204;
  localparam logic [11:0] OFF_MUX_SEL  = 12'h214;
  localparam logic [11:0] OFF_FLASH    = 12'h23c;
  localparam logic [11:0] OFF_ALL_ONES = 12'h254;
  localparam logic [11:0] OFF_AD_VAL   = 12'h257;
  localparam logic [11:0] OFF_VERSION  = 12'h390;
  localparam logic [11:0] OFF_ENVM_W0  = 12'h3c4;
  localparam logic [11:0] OFF_ENVM_RD  = 12'h3c8;
  localparam logic [11:0] OFF_ENVM_W2  = 12'h3cc;
  localparam logic [11:0] OFF_ID_BYTE  = 12'h3d6;
  localparam logic [11:0] OFF_STAT_A   = 12'h40c;
  localparam logic [11:0] OFF_CMD_A    = 12'h414;
  localparam logic [11:0] OFF_HOLD_A   = 12'h41c;
  localparam logic [11:0] OFF_INT      = 12'h42c;
  localparam logic [11:0] OFF_STAT_B   = 12'h44c;
  localparam logic [11:0] OFF_CMD_B    = 12'h454;
  localparam logic [11:0] OFF_HOLD_B   = 12'h45c;

  // Configuration register indexes
  localparam logic [1:0] REG_SLOT    = 2'd0;
  localparam logic [1:0] REG_SUPPLY  = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;
  localparam logic [1:0] REG_FLASH   = 2'd3;

  // Configuration reset values
  localparam logic [1:0]  SUPPLY_RST  = 2'd3;
  localparam logic [15:0] VERSION_RST = 16'h0102;
  localparam logic [15:0] FLASH_RST   = 16'h2704;

  // Interrupt status bits
  localparam logic [7:0] ST_TXRDYA = 8'h01;
  localparam logic [7:0] ST_RXRDYA = 8'h02;
  localparam logic [7:0] ST_TXRDYB = 8'h10;
  localparam logic [7:0] ST_RXRDYB = 8'h20;

  // Fixed read values
  localparam logic [31:0] UART_STAT_BASE = 32'h0000_0004;
  localparam logic [31:0] IO_CTRL_SET    = 32'h0000_0004;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_BYTE        = 32'h0000_0033;
  localparam logic [3:0]  CMD_FLUSH_BIT  = 4'd3;

  // A/D converter reading, sample over divisor worked out at elaboration
  localparam int unsigned  AD_SAMPLE  = 1150;
  localparam int unsigned  AD_DIVISOR = 9;
  localparam logic [31:0]  AD_VALUE   = 32'(AD_SAMPLE / AD_DIVISOR);

  // Analog mux codes
  localparam logic [31:0] MUX_PS0  = 32'h00;
  localparam logic [31:0] MUX_PS1  = 32'h02;
  localparam logic [31:0] MUX_AD_A = 32'h04;
  localparam logic [31:0] MUX_AD_B = 32'h08;
  localparam logic [31:0] MUX_AD_C = 32'h0a;
  localparam logic [31:0] MUX_AD_D = 32'h0c;

  // Input word held in the input register
  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic        con_char_avail;
    logic        aux_char_avail;
    logic [7:0]  con_rx_char;
    logic [7:0]  aux_rx_char;
  } in_item_t;

  // Result word held in the output register
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        tx_con_valid;
    logic        tx_aux_valid;
    logic [7:0]  tx_char;
    logic        flush_con;
    logic        flush_aux;
  } res_item_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Environmental monitor table, unknown keys read zero
  function automatic logic [15:0] envm_value(input logic [31:0] key);
    logic [15:0] val;
    case (key)
      32'h2a00: val = 16'h3000;
      32'h4c00: val = 16'h02a9;
      32'h4c01: val = 16'h0135;
      32'h4c02: val = 16'h0204;
      32'h4c03: val = 16'h0173;
      32'h4c04: val = 16'h00f7;
      32'h4c05: val = 16'h0108;
      32'h4800: val = 16'h0204;
      32'h4801: val = 16'h00f9;
      32'h4802: val = 16'h02c8;
      32'h4803: val = 16'h0260;
      32'h4804: val = 16'h0111;
      32'h4805: val = 16'h0111;
      32'h4806: val = 16'h03f8;
      32'h4807: val = 16'h033d;
      default:  val = 16'h0000;
    endcase
    return val;
  endfunction

endpackage

/* sv/io_fpga_duart_envm_registers_core.sv */
// ----------------------------------------------------------------------------
// io_fpga_duart_envm_registers_core
// Board I/O register block: bus register file, DUART interrupt unit and
// environmental monitor words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item: a bus
//   read, a bus write, a console or aux receive event, or a tick. Output
//   channel (out_valid_o / out_stall_i) returns exactly one result word per
//   input word, in order: read data, interrupt level, transmit strobes and
//   character, flush strobes.
//   A word passes an input register and then an output register. The block
//   takes one word every cycle while the output is not stalled; the
//   interrupt and I/O state is updated as a word moves from the input
//   register to the output register, so each word sees the state left by
//   the one before it.
//   When the receiver stalls, the result holds in the output register and
//   one more word can wait in the input register; after that in_stall_o is
//   raised until the output register frees up.
//   Reset clears all state and returns the configuration registers (APB port)
//   to their defaults: no slot card, both supplies present, default version
//   and flash code. The user must write configuration only while the block
//   is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module io_fpga_duart_envm_registers_core import ioenvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic        con_char_avail_i,
  input  logic        aux_char_avail_i,
  input  logic [7:0]  con_rx_char_i,
  input  logic [7:0]  aux_rx_char_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_line_o,
  output logic        tx_con_valid_o,
  output logic        tx_aux_valid_o,
  output logic [7:0]  tx_char_o,
  output logic        flush_con_o,
  output logic        flush_aux_o
);

  // Configuration registers
  logic        slot_q;
  logic [1:0]  supply_q;
  logic [15:0] version_q;
  logic [15:0] flash_q;
  logic        cfg_wr;

  // Block state
  logic [7:0]  int_status_q, int_status_d;
  logic [7:0]  int_mask_q, int_mask_d;
  logic        irq_q, irq_d;
  logic        phase_q, phase_d;
  logic [31:0] io_ctrl_q, io_ctrl_d;
  logic [31:0] mux_sel_q, mux_sel_d;
  logic [28:0] envm_w0_q, envm_w0_d;   // swapped word 0, bits 31:3
  logic [7:0]  envm_w2_q, envm_w2_d;   // swapped word 2, bits 7:0

  // Pipeline registers
  logic        s1_valid_q;
  in_item_t    s1_q;
  logic        out_valid_q;
  res_item_t   out_q;
  res_item_t   res;
  logic        in_acc;
  logic        out_load;

  logic [31:0] swap_wd;
  logic [31:0] envm_key;
  logic [31:0] ad_val;

  // APB port: always ready, write on access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= 1'b0;
      supply_q  <= SUPPLY_RST;
      version_q <= VERSION_RST;
      flash_q   <= FLASH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLOT:    slot_q    <= pwdata[0];
        REG_SUPPLY:  supply_q  <= pwdata[1:0];
        REG_VERSION: version_q <= pwdata[15:0];
        REG_FLASH:   flash_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLOT:    prdata = {31'b0, slot_q};
      REG_SUPPLY:  prdata = {30'b0, supply_q};
      REG_VERSION: prdata = {16'b0, version_q};
      REG_FLASH:   prdata = {16'b0, flash_q};
      default:     prdata = '0;
    endcase
  end

  // Handshake: advance the input register whenever the output register frees
  assign out_load   = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~out_load;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.mode           <= mode_i;
      s1_q.offset         <= offset_i;
      s1_q.write_data     <= write_data_i;
      s1_q.con_char_avail <= con_char_avail_i;
      s1_q.aux_char_avail <= aux_char_avail_i;
      s1_q.con_rx_char    <= con_rx_char_i;
      s1_q.aux_rx_char    <= aux_rx_char_i;
    end
  end

  // Monitor lookup key and A/D reading from current state
  assign swap_wd  = bswap32(s1_q.write_data);
  assign envm_key = {16'b0, envm_w2_q, 8'b0} | {3'b0, envm_w0_q};

  always_comb begin
    ad_val = '0;
    if (mux_sel_q == MUX_PS0) begin
      if (supply_q[0]) ad_val = AD_VALUE;
    end else if (mux_sel_q == MUX_PS1) begin
      if (supply_q[1]) ad_val = AD_VALUE;
    end else if (mux_sel_q inside {MUX_AD_A, MUX_AD_B, MUX_AD_C, MUX_AD_D}) begin
      ad_val = AD_VALUE;
    end
  end

  // Decode the item and work out the next state and its result
  always_comb begin
    int_status_d = int_status_q;
    int_mask_d   = int_mask_q;
    irq_d        = irq_q;
    phase_d      = phase_q;
    io_ctrl_d    = io_ctrl_q;
    mux_sel_d    = mux_sel_q;
    envm_w0_d    = envm_w0_q;
    envm_w2_d    = envm_w2_q;
    res          = '0;

    case (s1_q.mode)
      MODE_READ: begin
        case (s1_q.offset)
          OFF_IO_CTRL:  res.read_data = io_ctrl_q | IO_CTRL_SET;
          OFF_FLASH:    res.read_data = {16'b0, flash_q};
          OFF_ALL_ONES: res.read_data = ALL_ONES;
          OFF_AD_VAL:   res.read_data = ad_val;
          OFF_VERSION:  res.read_data = {7'b0, slot_q, 8'b0, version_q};
          OFF_ENVM_RD:  res.read_data = bswap32({16'b0, envm_value(envm_key)});
          OFF_ID_BYTE:  res.read_data = ID_BYTE;
          OFF_STAT_A: begin
            res.read_data = UART_STAT_BASE | {31'b0, s1_q.con_char_avail};
            irq_d = 1'b0;
          end
          OFF_HOLD_A: begin
            res.read_data = {24'b0, s1_q.con_rx_char};
            int_status_d  = int_status_q & ~ST_RXRDYA;
          end
          OFF_INT:      res.read_data = {24'b0, int_status_q};
          OFF_STAT_B:   res.read_data = UART_STAT_BASE | {31'b0, s1_q.aux_char_avail};
          OFF_HOLD_B: begin
            res.read_data = {24'b0, s1_q.aux_rx_char};
            int_status_d  = int_status_q & ~ST_RXRDYB;
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (s1_q.offset)
          OFF_IO_CTRL: io_ctrl_d = s1_q.write_data;
          OFF_MUX_SEL: mux_sel_d = s1_q.write_data;
          OFF_ENVM_W0: envm_w0_d = swap_wd[31:3];
          OFF_ENVM_W2: envm_w2_d = swap_wd[7:0];
          OFF_CMD_A:   res.flush_con = s1_q.write_data[CMD_FLUSH_BIT];
          OFF_HOLD_A: begin
            res.tx_con_valid = 1'b1;
            res.tx_char      = s1_q.write_data[7:0];
            int_status_d     = int_status_q & ~ST_TXRDYA;
          end
          OFF_INT:     int_mask_d = s1_q.write_data[7:0];
          OFF_CMD_B:   res.flush_aux = s1_q.write_data[CMD_FLUSH_BIT];
          OFF_HOLD_B: begin
            res.tx_aux_valid = 1'b1;
            res.tx_char      = s1_q.write_data[7:0];
            int_status_d     = int_status_q & ~ST_TXRDYB;
          end
          default: ;
        endcase
      end
      MODE_CON_RX: begin
        if ((int_mask_q & ST_RXRDYA) != '0) begin
          int_status_d = int_status_q | ST_RXRDYA;
          irq_d        = 1'b1;
        end
      end
      MODE_AUX_RX: begin
        if ((int_mask_q & ST_RXRDYB) != '0) begin
          int_status_d = int_status_q | ST_RXRDYB;
          irq_d        = 1'b1;
        end
      end
      MODE_TICK: begin
        // every second tick raises both transmit-ready bits if either is unmasked
        phase_d = ~phase_q;
        if (phase_q && ((int_mask_q & (ST_TXRDYA | ST_TXRDYB)) != '0)) begin
          int_status_d = int_status_q | ST_TXRDYA | ST_TXRDYB;
          irq_d        = 1'b1;
        end
      end
      default: ;
    endcase

    res.irq_line = irq_d;
  end

  // Commit state as the word moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_status_q <= '0;
      int_mask_q   <= '0;
      irq_q        <= 1'b0;
      phase_q      <= 1'b0;
      io_ctrl_q    <= '0;
      mux_sel_q    <= '0;
      envm_w0_q    <= '0;
      envm_w2_q    <= '0;
    end else if (out_load) begin
      int_status_q <= int_status_d;
      int_mask_q   <= int_mask_d;
      irq_q        <= irq_d;
      phase_q      <= phase_d;
      io_ctrl_q    <= io_ctrl_d;
      mux_sel_q    <= mux_sel_d;
      envm_w0_q    <= envm_w0_d;
      envm_w2_q    <= envm_w2_d;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_q.read_data;
  assign irq_line_o     = out_q.irq_line;
  assign tx_con_valid_o = out_q.tx_con_valid;
  assign tx_aux_valid_o = out_q.tx_aux_valid;
  assign tx_char_o      = out_q.tx_char;
  assign flush_con_o    = out_q.flush_con;
  assign flush_aux_o    = out_q.flush_aux;

endmodule
